/* hdl/ordered_list_insert_delete_unit_assert.svh */
// Assertion macros shared by the ordered list RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ORDERED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OLID_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ordered list assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OLID_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ordered list assertion failed");

`endif

/* hdl/olid_pkg.sv */
// Shared types and codes of the ordered list unit.
// Depends on nothing; used by the cell and the top module of the unit.
package olid_pkg;

   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 7;

   // Operation codes carried by a request word.
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE_VAL = 3'd3;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_AT    = 3'd5;

   // Status codes carried by a response word.
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Per-cell update command.
   typedef struct packed {
      logic take_left;
      logic take_right;
      logic load_new;
   } cell_ctrl_type;

endpackage

/* hdl/olid_cell.sv */
// One storage cell of the ordered list chain.
// Depends on olid_pkg for the value width and the cell command struct.
module olid_cell (
   input  logic                             clock,
   input  olid_pkg::cell_ctrl_type          ctrl,
   input  logic [olid_pkg::VALUE_W-1:0]     left_data,
   input  logic [olid_pkg::VALUE_W-1:0]     right_data,
   input  logic [olid_pkg::VALUE_W-1:0]     new_value,
   input  logic [olid_pkg::VALUE_W-1:0]     key,
   output logic [olid_pkg::VALUE_W-1:0]     data_out,
   output logic                             hit_out
);

   logic [olid_pkg::VALUE_W-1:0] data_ff;
   logic [olid_pkg::VALUE_W-1:0] data_in;

   // Pick the next content: the neighbor in front, the neighbor behind, or a new word.
   always_comb begin
      data_in = data_ff;
      if (ctrl.load_new) begin
         data_in = new_value;
      end else if (ctrl.take_left) begin
         data_in = left_data;
      end else if (ctrl.take_right) begin
         data_in = right_data;
      end
   end

   // The content needs no reset; it is undefined until written.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign hit_out  = (data_ff == key);

endmodule

/* hdl/olid_prefix_or.sv */
// Log-depth prefix OR over the cell hit vector; bit i is set when any hit at or
// in front of cell i is set. Depends on nothing.
module olid_prefix_or #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] hits,
   output logic [WIDTH-1:0] seen
);

   localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] level_vec [LEVELS+1];

   assign level_vec[0] = hits;

   // Each level folds in the partial result from 2**l cells further front.
   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar i = 0; i < WIDTH; i++) begin : g_bit
         if (i >= (1 << l)) begin : g_or
            assign level_vec[l+1][i] = level_vec[l][i] | level_vec[l][i-(1<<l)];
         end else begin : g_pass
            assign level_vec[l+1][i] = level_vec[l][i];
         end
      end
   end

   assign seen = level_vec[LEVELS];

endmodule

/* hdl/ordered_list_insert_delete_unit.sv */
// Ordered list of signed 32-bit words held in a chain of CAPACITY cells, cell 0
// being the front. A request word is registered when taken and executed in the next cycle:
// every cell compares its word with the key at once, a prefix OR finds the first
// hit, and the cells shift by one place toward the back (insert) or the front
// (delete, pop) in that same cycle. Each request returns one response word; a new
// request is taken only in the idle state, once the response register is free or
// being emptied. The cell contents need no clearing after reset. Depends on
// olid_pkg, olid_cell, olid_prefix_or and the assertion header.
`include "ordered_list_insert_delete_unit_assert.svh"

module ordered_list_insert_delete_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [olid_pkg::OP_W-1:0]              req_opcode,
   input  logic signed [olid_pkg::VALUE_W-1:0]    req_item_value,
   input  logic [olid_pkg::POS_W-1:0]             req_item_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [olid_pkg::STAT_W-1:0]            rsp_status,
   output logic signed [olid_pkg::VALUE_W-1:0]    rsp_value_out,
   output logic [olid_pkg::OCC_W-1:0]             rsp_occupancy
);

   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int CMPW     = (CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W;
   localparam int RD_CELLS = (CAPACITY < (1 << olid_pkg::POS_W)) ?
                             CAPACITY : (1 << olid_pkg::POS_W);

   olid_pkg::state_type state_ff, state_in;

   logic [olid_pkg::OP_W-1:0]    op_ff;
   logic [olid_pkg::VALUE_W-1:0] key_ff;
   logic [olid_pkg::POS_W-1:0]   pos_ff;
   logic [CW-1:0]                count_ff, count_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [olid_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [olid_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                         req_fire;
   logic                         exec;
   logic                         full;
   logic                         empty;
   logic                         pos_bad;
   logic                         found;
   logic                         do_insert;
   logic                         do_delete;
   logic [CW-1:0]                ins_pos;
   logic [olid_pkg::VALUE_W-1:0] rd_value;
   logic [CAPACITY-1:0]          hit_raw;
   logic [CAPACITY-1:0]          hit_valid;
   logic [CAPACITY-1:0]          seen;
   logic [CAPACITY-1:0]          del_sel;

   logic [olid_pkg::VALUE_W-1:0] cell_data [CAPACITY];
   olid_pkg::cell_ctrl_type      cell_ctrl [CAPACITY];

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == olid_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign exec      = (state_ff == olid_pkg::ST_EXEC);

   // Chain of cells; each takes its neighbors' words as shift sources.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic [olid_pkg::VALUE_W-1:0] left_word;
      logic [olid_pkg::VALUE_W-1:0] right_word;

      if (i == 0) begin : g_front
         assign left_word = key_ff;
      end else begin : g_inner_l
         assign left_word = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_back
         assign right_word = cell_data[i];
      end else begin : g_inner_r
         assign right_word = cell_data[i+1];
      end

      assign cell_ctrl[i].take_left  = do_insert && (IDX > ins_pos);
      assign cell_ctrl[i].load_new   = do_insert && (IDX == ins_pos);
      assign cell_ctrl[i].take_right = do_delete && del_sel[i];
      assign hit_valid[i]            = hit_raw[i] && (IDX < count_ff);

      olid_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .left_data  (left_word),
         .right_data (right_word),
         .new_value  (key_ff),
         .key        (key_ff),
         .data_out   (cell_data[i]),
         .hit_out    (hit_raw[i])
      );
   end

   // First hit: every cell at or behind it closes the gap.
   olid_prefix_or #(
      .WIDTH (CAPACITY)
   ) u_prefix (
      .hits (hit_valid),
      .seen (seen)
   );

   assign found = seen[CAPACITY-1];

   // Read port: the cell at the requested position drives the word.
   always_comb begin
      rd_value = '0;
      for (int j = 0; j < RD_CELLS; j++) begin
         if (pos_ff == olid_pkg::POS_W'(j)) begin
            rd_value = rd_value | cell_data[j];
         end
      end
   end

   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_bad = (CMPW'(pos_ff) >= CMPW'(count_ff));

   // Decode the operation in the execute cycle.
   always_comb begin
      do_insert     = 1'b0;
      do_delete     = 1'b0;
      ins_pos       = '0;
      del_sel       = seen;
      rsp_status_in = olid_pkg::STAT_OK;
      rsp_value_in  = '0;
      case (op_ff)
         olid_pkg::OP_PUSH_FRONT, olid_pkg::OP_PUSH_BACK, olid_pkg::OP_INSERT_AT: begin
            if (full) begin
               rsp_status_in = olid_pkg::STAT_FULL;
            end else if (op_ff == olid_pkg::OP_PUSH_FRONT || empty) begin
               do_insert = exec;
            end else if (op_ff == olid_pkg::OP_PUSH_BACK) begin
               do_insert = exec;
               ins_pos   = count_ff;
            end else if (pos_bad) begin
               rsp_status_in = olid_pkg::STAT_BADPOS;
            end else begin
               do_insert = exec;
               ins_pos   = CW'(pos_ff);
            end
         end
         olid_pkg::OP_DELETE_VAL: begin
            if (found) begin
               do_delete = exec;
            end else begin
               rsp_status_in = olid_pkg::STAT_EMPTY;
            end
         end
         olid_pkg::OP_POP_FRONT: begin
            del_sel = '1;
            if (empty) begin
               rsp_status_in = olid_pkg::STAT_EMPTY;
            end else begin
               do_delete    = exec;
               rsp_value_in = cell_data[0];
            end
         end
         olid_pkg::OP_READ_AT: begin
            if (empty) begin
               rsp_status_in = olid_pkg::STAT_EMPTY;
            end else if (pos_bad) begin
               rsp_status_in = olid_pkg::STAT_BADPOS;
            end else begin
               rsp_value_in = rd_value;
            end
         end
         default: begin
            rsp_status_in = olid_pkg::STAT_OK;
         end
      endcase
   end

   // Sequencer, count and response slot.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         olid_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = olid_pkg::ST_EXEC;
            end
         end
         olid_pkg::ST_EXEC: begin
            state_in     = olid_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            if (do_insert) begin
               count_in = count_ff + CW'(1);
            end else if (do_delete) begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            state_in = olid_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olid_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_opcode;
         key_ff <= req_item_value;
         pos_ff <= req_item_position;
      end
      if (exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_occupancy = olid_pkg::OCC_W'(count_ff);

   // A taken request is executed in the very next cycle.
   `OLID_ASSERT_NEXT(a_fire_exec, clock, reset, req_fire, exec)
   // The execute cycle always leaves a response behind.
   `OLID_ASSERT_NEXT(a_exec_rsp, clock, reset, exec, rsp_valid_ff)
   // Cells never shift both ways at once.
   `OLID_ASSERT_NOW(a_one_shift, clock, reset, exec, !(do_insert && do_delete))
   // The count never passes the capacity.
   `OLID_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   // After an execute cycle with a full list, the list is not empty.
   `OLID_ASSERT_NEXT(a_full_hold, clock, reset, exec && full, count_ff != '0)

endmodule
